### rtl/shs_pkg.sv
// shared types, constants and round functions of the sha-256 stream hasher
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef word_t       words8_t [8];
  typedef word_t       block_t [16];

  // one queued input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } item_t;

  // compression request from the controller to the round unit
  typedef struct packed {
    logic start;
    logic use_iv;
  } core_req_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam word_t      PAD_WORD  = 32'h8000_0000;
  localparam word_t      DBL_BITS  = 32'd256;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_LIMIT = 6'd56;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [2:0] LAST_IDX  = 3'd7;

  localparam words8_t IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // round constants
  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    round_k = k;
  endfunction

endpackage

### rtl/sha256_stream_hash.sv
// top level of the streaming sha-256 hasher
// Message bytes enter one per input transfer through a short queue, so the
// input takes a byte every cycle while the queue has room. Each 64-byte block
// goes through a round unit that does one round per cycle; since it copies
// the block on start, the next block fills while it works. On the end of a
// message one or two padding blocks follow, a further compression of the
// digest in double mode, and then eight digest words leave as eight output
// transfers, word 0 first. The next message may stream in during the digest
// output. The mode bit written through cfg_wdata_i is sampled on the item
// that ends a message.
module sha256_stream_hash import shs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  logic  head_valid;
  item_t head;
  logic  pop;

  // input queue
  shs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_message_i (end_of_message_i),
    .head_valid_o     (head_valid),
    .head_o           (head),
    .pop_i            (pop)
  );

  // hashing and output
  shs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

### rtl/shs_front.sv
// input front end: takes transfers, drops idle items, queues the rest
module shs_front import shs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       byte_valid_i,
  input  logic       end_of_message_i,
  output logic       head_valid_o,
  output item_t      head_o,
  input  logic       pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  item_t           queue_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  // idle items are taken but never queued
  assign in_stall_o   = (count_q == FullCnt);
  assign push         = in_valid_i && !in_stall_o && (byte_valid_i || end_of_message_i);
  assign pop          = pop_i && head_valid_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= '{data_byte: data_byte_i, byte_valid: byte_valid_i,
                            end_of_message: end_of_message_i};
    end
  end

endmodule

### rtl/shs_core.sv
// compression round unit: one round a cycle, keeps the chaining state
module shs_core import shs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_req_t req_i,
  input  block_t    blk_i,
  output logic      busy_o,
  output words8_t   hash_o
);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_ADD   = 2'd2;

  logic [1:0] state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  words8_t    hash_q;
  words8_t    v_q;
  block_t     win_q;
  word_t      t1, t2, w_next;

  assign busy_o = (state_q != C_IDLE);
  assign hash_o = hash_q;

  // round datapath and message schedule
  always_comb begin
    t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + round_k(rnd_q) + win_q[0];
    t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_next = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    unique case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          state_d = C_ROUND;
          rnd_d   = '0;
        end
      end
      C_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == LAST_RND) begin
          state_d = C_ADD;
        end
      end
      C_ADD: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  // working variables, schedule window and chaining state
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && req_i.start) begin
      win_q <= blk_i;
      if (req_i.use_iv) begin
        hash_q <= IV;
        v_q    <= IV;
      end else begin
        v_q    <= hash_q;
      end
    end else if (state_q == C_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_next;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if (state_q == C_ADD) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_q[i] + v_q[i];
      end
    end
  end

endmodule

### rtl/shs_back.sv
// back end: block assembly, padding, double hash and digest output
module shs_back import shs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        head_valid_i,
  input  item_t       head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] B_RUN = 3'd0;
  localparam logic [2:0] B_PAD = 3'd1;
  localparam logic [2:0] B_LEN = 3'd2;
  localparam logic [2:0] B_FIN = 3'd3;
  localparam logic [2:0] B_DBL = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q;
  logic [60:0] total_q;
  logic        first_q, dbl_q, mode_q;
  word_t       buf_q [16];
  words8_t     dig_q;
  logic [2:0]  idx_q;
  logic        out_busy_q;

  core_req_t   req;
  block_t      blk, pad_blk;
  logic        core_busy;
  words8_t     hash;
  logic        fills, snap, out_xfer;
  word_t       len_hi, len_lo;
  logic [7:0]  pb;

  shs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .blk_i  (blk),
    .busy_o (core_busy),
    .hash_o (hash)
  );

  assign len_hi = total_q[60:29];
  assign len_lo = {total_q[28:0], 3'b000};
  assign fills  = head_i.byte_valid && (fill_q == LAST_BYTE);
  assign pop_o  = (state_q == B_RUN) && head_valid_i && !(fills && core_busy);

  // final block: bytes so far, the pad byte, zeros, and the length if it fits
  always_comb begin
    for (int w = 0; w < 16; w++) begin
      for (int l = 0; l < 4; l++) begin
        if (6'(w * 4 + 3 - l) < fill_q) begin
          pb = buf_q[w][l*8 +: 8];
        end else if (6'(w * 4 + 3 - l) == fill_q) begin
          pb = PAD_BYTE;
        end else begin
          pb = 8'h00;
        end
        pad_blk[w][l*8 +: 8] = pb;
      end
    end
    if (fill_q < LEN_LIMIT) begin
      pad_blk[14] = len_hi;
      pad_blk[15] = len_lo;
    end
  end

  // block and request towards the round unit
  always_comb begin
    req = '{start: 1'b0, use_iv: first_q};
    for (int i = 0; i < 16; i++) begin
      blk[i] = buf_q[i];
    end
    blk[15] = {buf_q[15][31:8], head_i.data_byte};
    unique case (state_q) inside
      B_RUN: req.start = pop_o && fills;
      B_PAD: begin
        blk       = pad_blk;
        req.start = !core_busy;
      end
      B_LEN: begin
        for (int i = 0; i < 14; i++) begin
          blk[i] = '0;
        end
        blk[14]   = len_hi;
        blk[15]   = len_lo;
        req.start = !core_busy;
      end
      B_FIN, B_DBL: begin
        for (int i = 0; i < 8; i++) begin
          blk[i] = hash[i];
        end
        blk[8] = PAD_WORD;
        for (int i = 9; i < 15; i++) begin
          blk[i] = '0;
        end
        blk[15]    = DBL_BITS;
        req.use_iv = 1'b1;
        req.start  = (state_q == B_FIN) && dbl_q && !core_busy;
      end
      default: req.start = 1'b0;
    endcase
  end

  // digest capture once the last compression is done and the output is free
  assign snap = !core_busy && !out_busy_q &&
                (((state_q == B_FIN) && !dbl_q) || (state_q == B_DBL));

  // controller state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_RUN: if (pop_o && head_i.end_of_message) state_d = B_PAD;
      B_PAD: if (!core_busy) state_d = (fill_q < LEN_LIMIT) ? B_FIN : B_LEN;
      B_LEN: if (!core_busy) state_d = B_FIN;
      B_FIN: begin
        if (!core_busy && dbl_q) begin
          state_d = B_DBL;
        end else if (snap) begin
          state_d = B_RUN;
        end
      end
      B_DBL: if (snap) state_d = B_RUN;
      default: state_d = B_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_RUN;
      fill_q  <= '0;
      total_q <= '0;
      first_q <= 1'b1;
      dbl_q   <= 1'b0;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (pop_o && head_i.byte_valid) begin
        fill_q  <= fill_q + 1'b1;
        total_q <= total_q + 1'b1;
      end
      if (pop_o && head_i.end_of_message) begin
        dbl_q <= mode_q;
      end
      if (req.start) begin
        first_q <= 1'b0;
      end
      if (snap) begin
        fill_q  <= '0;
        total_q <= '0;
        first_q <= 1'b1;
      end
    end
  end

  // byte packing, big-endian within each word
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.byte_valid) begin
      buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= head_i.data_byte;
    end
  end

  // digest output register
  assign out_xfer      = out_valid_o && !out_stall_i;
  assign out_valid_o   = out_busy_q;
  assign digest_word_o = dig_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_busy_q <= 1'b0;
      idx_q      <= '0;
    end else if (snap) begin
      out_busy_q <= 1'b1;
      idx_q      <= '0;
    end else if (out_xfer) begin
      idx_q <= idx_q + 1'b1;
      if (idx_q == LAST_IDX) begin
        out_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap) begin
      dig_q <= hash;
    end
  end

endmodule
